FILE: hdl/led_light_profile_generator_macros.svh
// assertion helpers shared by the light profile generator
`ifndef LED_LIGHT_PROFILE_GENERATOR_MACROS_SVH
`define LED_LIGHT_PROFILE_GENERATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LLPG_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LLPG_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/llpg_pkg.sv
package llpg_pkg;

    // mode codes
    localparam logic [2:0] FUNC_NIGHT   = 3'd0;
    localparam logic [2:0] FUNC_DAY     = 3'd1;
    localparam logic [2:0] FUNC_SUNRISE = 3'd2;
    localparam logic [2:0] FUNC_SUNSET  = 3'd3;
    localparam logic [2:0] FUNC_ALL_ON  = 3'd4;
    localparam logic [2:0] FUNC_ALL_OFF = 3'd5;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_RED_MAX    = 3'd0;
    localparam logic [2:0] REG_GREEN_MAX  = 3'd1;
    localparam logic [2:0] REG_BLUE_MAX   = 3'd2;
    localparam logic [2:0] REG_WHITE_MAX  = 3'd3;
    localparam logic [2:0] REG_NIGHT_PEAK = 3'd4;

    localparam int ADDR_W = 5;
    localparam int LANES = 7;
    localparam int RAMP_LANES = 6;
    localparam logic [7:0] LEVEL_FULL = 8'hFF;
    localparam logic [11:0] BRIGHT_FULL = 12'hFFF;

    // night bumps
    localparam int NIGHT_STEP = 42;
    localparam int NIGHT_SPAN = 1764;
    localparam int NIGHT_FADE = 10;
    // day parabola
    localparam int DAY_CENTER = 125;
    localparam int DAY_SPAN = 15625;
    // sunrise / sunset ramps
    localparam int RAMP_STEP = 42;
    localparam int RAMP_END = 255;

    // exact division by constants: q = (n * ceil(2^s / d)) >> s, s = n_bits + ceil(log2 d)
    localparam longint unsigned NightDen = 64'd17640;
    localparam int NIGHT_SHIFT = 38;
    localparam logic [23:0] NIGHT_RECIP =
        24'(((64'd1 << NIGHT_SHIFT) + NightDen - 64'd1) / NightDen);

    localparam longint unsigned DayDen = 64'd15625;
    localparam int DAY_SHIFT = 40;
    localparam logic [26:0] DAY_RECIP =
        27'(((64'd1 << DAY_SHIFT) + DayDen - 64'd1) / DayDen);

    localparam longint unsigned RedDen = 64'd100;
    localparam int RED_SHIFT = 23;
    localparam logic [16:0] RED_RECIP =
        17'(((64'd1 << RED_SHIFT) + RedDen - 64'd1) / RedDen);

    localparam longint unsigned BlueDen = 64'd35000;
    localparam int BLUE_SHIFT = 40;
    localparam logic [24:0] BLUE_RECIP =
        25'(((64'd1 << BLUE_SHIFT) + BlueDen - 64'd1) / BlueDen);

    localparam longint unsigned WhiteDen = 64'd255;
    localparam int WHITE_SHIFT = 24;
    localparam logic [16:0] WHITE_RECIP =
        17'(((64'd1 << WHITE_SHIFT) + WhiteDen - 64'd1) / WhiteDen);

    localparam longint unsigned RampDen = 64'd42;
    localparam int RAMP_SHIFT = 24;
    localparam logic [18:0] RAMP_RECIP =
        19'(((64'd1 << RAMP_SHIFT) + RampDen - 64'd1) / RampDen);

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] phase;
    } llpg_cmd_t;

    typedef struct packed {
        logic [7:0]  red_level;
        logic [7:0]  green_level;
        logic [7:0]  blue_level;
        logic [7:0]  white_level;
        logic [11:0] bright_zero;
        logic [11:0] bright_one;
        logic [11:0] bright_two;
        logic [11:0] bright_three;
        logic [11:0] bright_four;
        logic [11:0] bright_five;
        logic [11:0] bright_six;
    } llpg_res_t;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } llpg_adv_t;

    typedef logic [LANES-1:0][11:0] llpg_bright_vec_t;
    typedef logic [RAMP_LANES-1:0][11:0] llpg_ramp_vec_t;

endpackage

FILE: hdl/llpg_night.sv
module llpg_night (
    input  logic                        clk,
    input  llpg_pkg::llpg_adv_t         adv,
    input  logic [7:0]                  phase,
    input  logic [7:0]                  night_peak,
    output llpg_pkg::llpg_bright_vec_t  bright
);
    import llpg_pkg::*;

    logic [LANES-1:0][10:0] x_next;
    logic [LANES-1:0][10:0] x_reg;
    logic [3:0]             fade;
    logic [11:0]            pk_next;
    logic [11:0]            pk_reg;
    logic [LANES-1:0][22:0] prod_reg;
    logic [LANES-1:0][46:0] wide;
    logic [LANES-1:0][11:0] bright_reg;

    // stage 1: bump shape per lane, 1764 - d^2 inside the bump
    always_comb
    begin
        logic signed [9:0] diff;
        logic [8:0]        mag;
        logic [11:0]       sq;
        diff = '0;
        mag = '0;
        sq = '0;
        for (int i = 0; i < LANES; i++)
        begin
            diff = $signed({2'b00, phase}) - $signed(10'(NIGHT_STEP * i));
            mag = diff[9] ? 9'(-diff) : diff[8:0];
            sq = 12'(mag[5:0]) * 12'(mag[5:0]);
            x_next[i] = (mag < 9'(NIGHT_STEP)) ? 11'(12'(NIGHT_SPAN) - sq) : '0;
        end
    end

    // stage 1: fade in and out at both ends of the period, scaled by peak
    always_comb
    begin
        if (phase < 8'(NIGHT_FADE))
            fade = phase[3:0];
        else if (phase > 8'(255 - NIGHT_FADE))
            fade = 4'(~phase);
        else
            fade = 4'(NIGHT_FADE);
        pk_next = 12'(night_peak) * 12'(fade);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            x_reg <= x_next;
            pk_reg <= pk_next;
        end
    end

    // stage 2: numerator per lane
    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            for (int i = 0; i < LANES; i++)
                prod_reg[i] <= 23'(pk_reg) * 23'(x_reg[i]);
        end
    end

    // stage 3: divide by 17640 through reciprocal multiply
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            wide[i] = 47'(prod_reg[i]) * 47'(NIGHT_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            for (int i = 0; i < LANES; i++)
                bright_reg[i] <= 12'(wide[i][NIGHT_SHIFT +: 8]);
        end
    end

    assign bright = bright_reg;

endmodule

FILE: hdl/llpg_day.sv
module llpg_day (
    input  logic                clk,
    input  llpg_pkg::llpg_adv_t adv,
    input  logic [7:0]          phase,
    output logic [11:0]         bright
);
    import llpg_pkg::*;

    logic signed [8:0] diff;
    logic [7:0]        mag;
    logic [15:0]       sq;
    logic [13:0]       x_next;
    logic [13:0]       x_reg;
    logic [25:0]       n_reg;
    logic [52:0]       wide;
    logic [11:0]       bright_reg;

    // stage 1: 15625 - (p - 125)^2, zero outside the parabola
    always_comb
    begin
        diff = $signed({1'b0, phase}) - $signed(9'(DAY_CENTER));
        mag = diff[8] ? 8'(-diff) : diff[7:0];
        sq = 16'(mag) * 16'(mag);
        x_next = (mag < 8'(DAY_CENTER)) ? 14'(16'(DAY_SPAN) - sq) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
            x_reg <= x_next;
    end

    // stage 2: scale to full brightness
    always_ff @(posedge clk)
    begin
        if (adv.s2)
            n_reg <= 26'(x_reg) * 26'(BRIGHT_FULL);
    end

    // stage 3: divide by 15625
    assign wide = 53'(n_reg) * 53'(DAY_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv.s3)
            bright_reg <= wide[DAY_SHIFT +: 12];
    end

    assign bright = bright_reg;

endmodule

FILE: hdl/llpg_dusk.sv
module llpg_dusk (
    input  logic                     clk,
    input  llpg_pkg::llpg_adv_t      adv,
    input  logic [2:0]               func,
    input  logic [7:0]               phase,
    output logic [9:0]               red_q,
    output logic [7:0]               green_q,
    output logic [8:0]               blue_q,
    output logic [7:0]               white_q,
    output llpg_pkg::llpg_ramp_vec_t ramp
);
    import llpg_pkg::*;

    logic [7:0]                  t;
    logic [7:0]                  u;
    logic [RAMP_LANES-1:0][5:0]  vc_next;
    logic [7:0]                  u_reg;
    logic [15:0]                 u2_reg;
    logic [RAMP_LANES-1:0][5:0]  vc_reg;
    logic [15:0]                 rn_reg;
    logic [7:0]                  gn_reg;
    logic [23:0]                 bn_reg;
    logic [15:0]                 wn_reg;
    logic [RAMP_LANES-1:0][17:0] ln_reg;
    logic [32:0]                 red_wide;
    logic [48:0]                 blue_wide;
    logic [32:0]                 white_wide;
    logic [RAMP_LANES-1:0][36:0] ramp_wide;
    logic [9:0]                  red_reg;
    logic [7:0]                  green_reg;
    logic [8:0]                  blue_reg;
    logic [7:0]                  white_reg;
    logic [RAMP_LANES-1:0][11:0] ramp_reg;

    // stage 1: sunrise mirrors the phase
    assign t = (func == FUNC_SUNRISE) ? ~phase : phase;
    assign u = ~t;

    // stage 1: ramp position per cluster, clamped to 0..42
    always_comb
    begin
        logic [9:0]        ofs;
        logic signed [9:0] v;
        ofs = '0;
        v = '0;
        for (int i = 0; i < RAMP_LANES; i++)
        begin
            ofs = (i == RAMP_LANES - 1) ? 10'(RAMP_END) : 10'(RAMP_STEP * (i + 1));
            v = $signed(ofs) - $signed({2'b00, t});
            if (v[9] || v == '0)
                vc_next[i] = '0;
            else if (v >= $signed(10'(RAMP_STEP)))
                vc_next[i] = 6'(RAMP_STEP);
            else
                vc_next[i] = v[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            u_reg <= u;
            u2_reg <= 16'(u) * 16'(u);
            vc_reg <= vc_next;
        end
    end

    // stage 2: numerators of the colour curves and ramps
    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            rn_reg <= 16'(u_reg) * 16'(LEVEL_FULL);
            gn_reg <= u_reg;
            bn_reg <= 24'(u2_reg) * 24'(LEVEL_FULL);
            wn_reg <= u2_reg;
            for (int i = 0; i < RAMP_LANES; i++)
                ln_reg[i] <= 18'(vc_reg[i]) * 18'(BRIGHT_FULL);
        end
    end

    // stage 3: constant divides through reciprocal multiplies
    assign red_wide = 33'(rn_reg) * 33'(RED_RECIP);
    assign blue_wide = 49'(bn_reg) * 49'(BLUE_RECIP);
    assign white_wide = 33'(wn_reg) * 33'(WHITE_RECIP);

    always_comb
    begin
        for (int i = 0; i < RAMP_LANES; i++)
            ramp_wide[i] = 37'(ln_reg[i]) * 37'(RAMP_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            red_reg <= red_wide[RED_SHIFT +: 10];
            green_reg <= gn_reg;
            blue_reg <= blue_wide[BLUE_SHIFT +: 9];
            white_reg <= white_wide[WHITE_SHIFT +: 8];
            for (int i = 0; i < RAMP_LANES; i++)
                ramp_reg[i] <= ramp_wide[i][RAMP_SHIFT +: 12];
        end
    end

    assign red_q = red_reg;
    assign green_q = green_reg;
    assign blue_q = blue_reg;
    assign white_q = white_reg;
    assign ramp = ramp_reg;

endmodule

FILE: hdl/led_light_profile_generator.sv
// path: a cmd passes the stage 1, 2 and 3 registers and then the res register; a stalled res holds it back
// throughput: one cmd transfer per cycle unless cmd_stall is raised, four pipeline stages with valid bits
// the three arithmetic stages hold the multiplies; the fourth clamps and selects
// reset clears the stage valid bits and sets all five registers to 255
// cmd_stall rises only when every stage holds an item and res is stalled
`include "led_light_profile_generator_macros.svh"

module led_light_profile_generator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  llpg_pkg::llpg_cmd_t       cmd,
    output logic                      res_valid,
    input  logic                      res_stall,
    output llpg_pkg::llpg_res_t       res,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [llpg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import llpg_pkg::*;

    logic [7:0]        red_max_reg;
    logic [7:0]        green_max_reg;
    logic [7:0]        blue_max_reg;
    logic [7:0]        white_max_reg;
    logic [7:0]        night_peak_reg;
    logic [2:0]        reg_idx;
    logic              cfg_wr;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              v4_reg;
    logic              free1;
    logic              free2;
    logic              free3;
    logic              free4;
    llpg_adv_t         adv;
    logic [2:0]        func_s1_reg;
    logic [2:0]        func_s2_reg;
    logic [2:0]        func_s3_reg;
    llpg_bright_vec_t  night_br;
    logic [11:0]       day_br;
    logic [9:0]        red_q;
    logic [7:0]        green_q;
    logic [8:0]        blue_q;
    logic [7:0]        white_q;
    llpg_ramp_vec_t    ramp;
    llpg_res_t         res_next;
    llpg_res_t         res_reg;

    // configuration port
    assign pready = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_max_reg <= LEVEL_FULL;
            green_max_reg <= LEVEL_FULL;
            blue_max_reg <= LEVEL_FULL;
            white_max_reg <= LEVEL_FULL;
            night_peak_reg <= LEVEL_FULL;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_RED_MAX:    red_max_reg <= pwdata[7:0];
                REG_GREEN_MAX:  green_max_reg <= pwdata[7:0];
                REG_BLUE_MAX:   blue_max_reg <= pwdata[7:0];
                REG_WHITE_MAX:  white_max_reg <= pwdata[7:0];
                REG_NIGHT_PEAK: night_peak_reg <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RED_MAX:    prdata = {24'd0, red_max_reg};
            REG_GREEN_MAX:  prdata = {24'd0, green_max_reg};
            REG_BLUE_MAX:   prdata = {24'd0, blue_max_reg};
            REG_WHITE_MAX:  prdata = {24'd0, white_max_reg};
            REG_NIGHT_PEAK: prdata = {24'd0, night_peak_reg};
            default:        prdata = '0;
        endcase
    end

    // stage load enables: a stage loads when empty or when its item moves on
    assign free4 = !v4_reg || !res_stall;
    assign free3 = !v3_reg || free4;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;
    assign adv = '{s1: free1, s2: free2, s3: free3};
    assign cmd_stall = !free1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (free1)
                v1_reg <= cmd_valid;
            if (free2)
                v2_reg <= v1_reg;
            if (free3)
                v3_reg <= v2_reg;
            if (free4)
                v4_reg <= v3_reg;
        end
    end

    // mode travels alongside the datapath
    always_ff @(posedge clk)
    begin
        if (free1)
            func_s1_reg <= cmd.func;
        if (free2)
            func_s2_reg <= func_s1_reg;
        if (free3)
            func_s3_reg <= func_s2_reg;
    end

    llpg_night u_night (
        .clk        (clk),
        .adv        (adv),
        .phase      (cmd.phase),
        .night_peak (night_peak_reg),
        .bright     (night_br)
    );

    llpg_day u_day (
        .clk    (clk),
        .adv    (adv),
        .phase  (cmd.phase),
        .bright (day_br)
    );

    llpg_dusk u_dusk (
        .clk     (clk),
        .adv     (adv),
        .func    (cmd.func),
        .phase   (cmd.phase),
        .red_q   (red_q),
        .green_q (green_q),
        .blue_q  (blue_q),
        .white_q (white_q),
        .ramp    (ramp)
    );

    // stage 4: pick the mode and, in sunrise and sunset, clamp to colour maxima
    always_comb
    begin
        logic [LANES-1:0][11:0] br;
        br = '0;
        res_next = '0;
        case (func_s3_reg)
            FUNC_NIGHT:
            begin
                res_next.white_level = LEVEL_FULL;
                br = night_br;
            end
            FUNC_DAY, FUNC_ALL_ON:
            begin
                res_next.red_level = red_max_reg;
                res_next.green_level = green_max_reg;
                res_next.blue_level = blue_max_reg;
                res_next.white_level = white_max_reg;
                for (int i = 0; i < LANES; i++)
                    br[i] = BRIGHT_FULL;
                if (func_s3_reg == FUNC_DAY)
                    br[LANES-1] = day_br;
            end
            FUNC_SUNRISE, FUNC_SUNSET:
            begin
                res_next.red_level = (red_q > 10'(red_max_reg)) ? red_max_reg : red_q[7:0];
                res_next.green_level = (green_q > green_max_reg) ? green_max_reg : green_q;
                res_next.blue_level = (blue_q > 9'(blue_max_reg)) ? blue_max_reg : blue_q[7:0];
                res_next.white_level = (white_q > white_max_reg) ? white_max_reg : white_q;
                // sunrise runs the clusters in reverse order
                for (int i = 0; i < RAMP_LANES; i++)
                    br[i] = (func_s3_reg == FUNC_SUNRISE) ? ramp[RAMP_LANES-1-i] : ramp[i];
            end
            default:
            begin
                br = '0;
            end
        endcase
        res_next.bright_zero = br[0];
        res_next.bright_one = br[1];
        res_next.bright_two = br[2];
        res_next.bright_three = br[3];
        res_next.bright_four = br[4];
        res_next.bright_five = br[5];
        res_next.bright_six = br[6];
    end

    always_ff @(posedge clk)
    begin
        if (free4)
            res_reg <= res_next;
    end

    assign res = res_reg;
    assign res_valid = v4_reg;

    // checks
    `LLPG_ASSERT_SAME(a_full_pipe_stalls, clk, rst_n, v1_reg && v2_reg && v3_reg && v4_reg && res_stall, cmd_stall, "full pipeline must stall input")
    `LLPG_ASSERT_SAME(a_free_takes_input, clk, rst_n, !v4_reg && !res_stall, !cmd_stall, "idle output stage must not stall input")
    `LLPG_ASSERT_NEXT(a_dusk_six_dark, clk, rst_n, free4 && v3_reg && (func_s3_reg == FUNC_SUNRISE || func_s3_reg == FUNC_SUNSET), res_reg.bright_six == '0, "cluster six lit in sunrise or sunset")
    `LLPG_ASSERT_NEXT(a_night_colour, clk, rst_n, free4 && v3_reg && func_s3_reg == FUNC_NIGHT, res_reg.white_level == LEVEL_FULL && res_reg.red_level == '0 && res_reg.blue_level == '0, "night colour wrong")
    `LLPG_ASSERT_NEXT(a_peak_write, clk, rst_n, cfg_wr && reg_idx == REG_NIGHT_PEAK, night_peak_reg == $past(pwdata[7:0]), "night peak write lost")

endmodule

FILE: tb/sv/tb_led_light_profile_generator.sv
module tb_led_light_profile_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import llpg_pkg::*;

    // mode codes the block treats as all off
    localparam logic [2:0] FUNC_SPARE_SIX   = 3'd6;
    localparam logic [2:0] FUNC_SPARE_SEVEN = 3'd7;
    // register indexes past the last register, writes there are dropped
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam longint FULL_BRIGHT = 4095;
    localparam int NUM_FIELDS = 11;
    localparam int DRAIN_CYCLES = 12;
    localparam int QUIET_LIMIT = 2000;
    localparam int ITEMS_PER_SETTING = 170;
    localparam int NUM_SETTINGS = 6;

    // expected light profiles and the register copy they are computed from
    class LightScoreboard;
        llpg_res_t  due_q[$];
        logic [7:0] red_max;
        logic [7:0] green_max;
        logic [7:0] blue_max;
        logic [7:0] white_max;
        logic [7:0] night_peak;
        int         failures;
        string      field_names[NUM_FIELDS];

        function new();
            red_max    = 8'hFF;
            green_max  = 8'hFF;
            blue_max   = 8'hFF;
            white_max  = 8'hFF;
            night_peak = 8'hFF;
            failures   = 0;
            field_names = '{"red_level", "green_level", "blue_level", "white_level",
                            "bright_zero", "bright_one", "bright_two", "bright_three",
                            "bright_four", "bright_five", "bright_six"};
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                REG_RED_MAX:    red_max = val;
                REG_GREEN_MAX:  green_max = val;
                REG_BLUE_MAX:   blue_max = val;
                REG_WHITE_MAX:  white_max = val;
                REG_NIGHT_PEAK: night_peak = val;
                default: ;
            endcase
        endfunction

        // floored quotient, zero when not positive, capped at hi
        function longint floor_clamp(longint num, longint den, longint hi);
            longint q;
            if (num <= 0)
            begin
                return 0;
            end
            q = num / den;
            return (q > hi) ? hi : q;
        endfunction

        function llpg_res_t light_profile(llpg_cmd_t c);
            llpg_res_t r;
            longint    p;
            longint    k;
            longint    d;
            longint    t;
            longint    u;
            longint    pk;
            longint    swap;
            longint    col[4];
            longint    br[7];
            p  = c.phase;
            pk = night_peak;
            foreach (col[i]) col[i] = 0;
            foreach (br[i]) br[i] = 0;
            case (c.func)
                // parabolic bumps with a fade at both ends of the period
                FUNC_NIGHT:
                begin
                    k = (p < 10) ? p : ((p > 245) ? 255 - p : 10);
                    col[3] = 255;
                    for (int i = 0; i < 7; i++)
                    begin
                        d = p - 42 * i;
                        br[i] = floor_clamp(pk * k * (1764 - d * d), 17640, FULL_BRIGHT);
                    end
                end
                // full colour, day adds a parabola on the last cluster
                FUNC_DAY, FUNC_ALL_ON:
                begin
                    col[0] = red_max;
                    col[1] = green_max;
                    col[2] = blue_max;
                    col[3] = white_max;
                    foreach (br[i]) br[i] = FULL_BRIGHT;
                    if (c.func == FUNC_DAY)
                    begin
                        d = p - 125;
                        br[6] = floor_clamp(FULL_BRIGHT * (15625 - d * d), 15625, FULL_BRIGHT);
                    end
                end
                // linear ramps, sunrise mirrors the phase and the clusters
                FUNC_SUNRISE, FUNC_SUNSET:
                begin
                    t = (c.func == FUNC_SUNRISE) ? 255 - p : p;
                    u = 255 - t;
                    col[0] = floor_clamp(255 * u, 100, longint'(red_max));
                    col[1] = floor_clamp(u, 1, longint'(green_max));
                    col[2] = floor_clamp(255 * u * u, 35000, longint'(blue_max));
                    col[3] = floor_clamp(u * u, 255, longint'(white_max));
                    for (int i = 0; i < 5; i++)
                    begin
                        br[i] = floor_clamp(FULL_BRIGHT * (42 * (i + 1) - t), 42, FULL_BRIGHT);
                    end
                    br[5] = floor_clamp(FULL_BRIGHT * (255 - t), 42, FULL_BRIGHT);
                    br[6] = 0;
                    if (c.func == FUNC_SUNRISE)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            swap = br[i];
                            br[i] = br[5 - i];
                            br[5 - i] = swap;
                        end
                    end
                end
                default: ;
            endcase
            r.red_level    = 8'(col[0]);
            r.green_level  = 8'(col[1]);
            r.blue_level   = 8'(col[2]);
            r.white_level  = 8'(col[3]);
            r.bright_zero  = 12'(br[0]);
            r.bright_one   = 12'(br[1]);
            r.bright_two   = 12'(br[2]);
            r.bright_three = 12'(br[3]);
            r.bright_four  = 12'(br[4]);
            r.bright_five  = 12'(br[5]);
            r.bright_six   = 12'(br[6]);
            return r;
        endfunction

        function void note_cmd(llpg_cmd_t c);
            due_q.push_back(light_profile(c));
        endfunction

        function void split(llpg_res_t r, output logic [11:0] v[NUM_FIELDS]);
            v = '{r.red_level, r.green_level, r.blue_level, r.white_level,
                  r.bright_zero, r.bright_one, r.bright_two, r.bright_three,
                  r.bright_four, r.bright_five, r.bright_six};
        endfunction

        function void check_res(llpg_res_t got);
            llpg_res_t   want;
            logic [11:0] gv[NUM_FIELDS];
            logic [11:0] wv[NUM_FIELDS];
            bit          bad;
            if (due_q.size() == 0)
            begin
                if (failures < 10)
                    $display("result transfer with nothing expected: %p", got);
                failures++;
                return;
            end
            want = due_q.pop_front();
            split(got, gv);
            split(want, wv);
            bad = 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                if (gv[i] !== wv[i])
                begin
                    bad = 1'b1;
                    if (failures < 10)
                        $display("mismatch on %s: expected %0d, got %0d",
                                 field_names[i], wv[i], gv[i]);
                end
            end
            if (bad)
                failures++;
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    llpg_cmd_t           cmd;
    logic                res_valid;
    logic                res_stall;
    llpg_res_t           res;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    LightScoreboard board = new();
    int send_idle = 0;
    int recv_idle = 0;
    int quiet_cycles = 0;

    led_light_profile_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            board.check_res(res);
        res_stall <= ($urandom_range(99) < recv_idle);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || psel)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no transfer for %0d cycles", QUIET_LIMIT);
                $display("[led_light_profile_generator] ERROR");
                $finish;
            end
        end
    end

    // one command transfer, with random idle cycles ahead of it
    task automatic send_cmd(input llpg_cmd_t c);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (cmd_stall);
        board.note_cmd(c);
    endtask

    // stop sending and wait until every expected result is in
    task automatic settle();
        cmd_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // setup then access phase of a register write
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom()), val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] w, input logic [7:0] n);
        write_reg(REG_RED_MAX, r);
        write_reg(REG_GREEN_MAX, g);
        write_reg(REG_BLUE_MAX, b);
        write_reg(REG_WHITE_MAX, w);
        write_reg(REG_NIGHT_PEAK, n);
    endtask

    initial
    begin
        logic [7:0] night_pts[12];
        logic [7:0] ramp_pts[3];
        llpg_cmd_t  c;
        int         sent;
        night_pts = '{8'd0, 8'd9, 8'd10, 8'd42, 8'd84, 8'd126, 8'd168, 8'd210,
                      8'd245, 8'd246, 8'd252, 8'd255};
        ramp_pts  = '{8'd0, 8'd255, 8'd100};
        sent = 0;

        // quiet inputs and reset
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        res_stall <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fade edges, bump centers, parabola peak, ramp ends, unused modes
        foreach (night_pts[i]) send_cmd('{FUNC_NIGHT, night_pts[i]});
        send_cmd('{FUNC_DAY, 8'd0});
        send_cmd('{FUNC_DAY, 8'd125});
        send_cmd('{FUNC_DAY, 8'd255});
        foreach (ramp_pts[i]) send_cmd('{FUNC_SUNRISE, ramp_pts[i]});
        foreach (ramp_pts[i]) send_cmd('{FUNC_SUNSET, ramp_pts[i]});
        send_cmd('{FUNC_ALL_ON, 8'h5A});
        send_cmd('{FUNC_ALL_OFF, 8'hA5});
        send_cmd('{FUNC_SPARE_SIX, 8'hFF});
        send_cmd('{FUNC_SPARE_SEVEN, 8'h00});

        // random items under several register settings
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            settle();
            case (s)
                0: load_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                1: load_regs(8'($urandom()), 8'($urandom()), 8'($urandom()),
                             8'($urandom()), 8'($urandom()));
                2:
                begin
                    load_regs(8'd255, 8'd0, 8'd255, 8'd0, 8'd1);
                    write_reg(REG_SPARE_LO, 8'($urandom()));
                end
                3:
                begin
                    load_regs(8'($urandom()), 8'($urandom()), 8'($urandom()),
                              8'($urandom()), 8'($urandom()));
                    write_reg(REG_SPARE_HI, 8'($urandom()));
                end
                4: load_regs(8'd0, 8'd255, 8'd0, 8'd255, 8'd128);
                default: load_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
            endcase
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                if (sent < 340)
                begin
                    send_idle = 14;
                    recv_idle = 48;
                end
                else if (sent < 680)
                begin
                    send_idle = 48;
                    recv_idle = 14;
                end
                else
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                c.func  = 3'($urandom_range(7));
                c.phase = 8'($urandom_range(255));
                send_cmd(c);
                sent++;
            end
        end

        // drain and report
        settle();
        if (board.failures == 0 && board.pending() == 0)
        begin
            $display("[led_light_profile_generator] OK");
        end
        else
        begin
            $display("[led_light_profile_generator] ERROR");
        end
        $finish;
    end

endmodule
